>>> hdl/biw_pkg.sv
// Shared constants, register codes and types for the broadcast index walker.
// Depends on nothing; used by broadcast_index_walker.
package biw_pkg;

    // Geometry of the walker
    localparam int MAX_DIMS     = 4;
    localparam int DIM_BITS     = 16;
    localparam int INDEX_BITS   = 32;
    localparam int DIM_IDX_BITS = $clog2(MAX_DIMS);

    // Configuration port geometry
    localparam int RANK_BITS      = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Exact element count tracking: one bit above the index width, and its product
    localparam int TOT_BITS  = INDEX_BITS + 1;
    localparam int PROD_BITS = TOT_BITS + DIM_BITS;

    // Stream widths
    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 3 * INDEX_BITS;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RANK       = 3'd0,
        CFG_DIM_SIZE_0 = 3'd1,
        CFG_DIM_SIZE_1 = 3'd2,
        CFG_DIM_SIZE_2 = 3'd3,
        CFG_DIM_SIZE_3 = 3'd4,
        CFG_LHS_MASK   = 3'd5,
        CFG_RHS_MASK   = 3'd6
    } cfg_reg_t;

    // Stride and offset recomputation after a configuration write
    typedef enum logic [1:0] {
        SETTLE_IDLE,
        SETTLE_STRIDE,
        SETTLE_PRODUCT
    } settle_state_t;

    // One result word
    typedef struct packed {
        logic [INDEX_BITS-1:0] out_index;
        logic [INDEX_BITS-1:0] lhs_index;
        logic [INDEX_BITS-1:0] rhs_index;
        logic                  last;
        logic                  size_error;
    } result_t;

endpackage

>>> hdl/broadcast_index_walker.sv
// Broadcast index walker: odometer address generator for broadcast elementwise ops.
// Depends on biw_pkg for geometry constants, register codes and the result type.
//
// Usage:
//   Configure through cfg_valid/cfg_ready/cfg_index/cfg_data (rank, four result sizes,
//   left and right broadcast masks) while the walker is idle. Each word on the s_ channel
//   requests the next element; s_tdata[0] set restarts the walk at element zero first.
//   Each request yields one word on the m_ channel: flat result index and both operand
//   indices in m_tdata, m_tlast on the final element of the walk (the walk then wraps),
//   and m_tuser set when the element count exceeds 2^32 (indices still wrap).
// Timing:
//   A result is registered in the output register, or in the skid register when stalled;
//   one request is taken every cycle unless busy or the skid is full. Indices are kept as
//   per-dimension partial offsets that step by their stride, so the per-cycle path is one
//   compare/add per dimension plus a four-way sum. After any configuration write, s_tready
//   stays low while shared 32x16 and 33x16 multipliers rebuild strides (one dimension a
//   cycle) and then the partial offsets for the held coordinates (one dimension a cycle).
// Reset and stalls:
//   Reset restores rank 1, all sizes 1, no broadcast, coordinates zero. A result word that
//   m_tready does not take waits in the output register; one more word goes to a skid
//   register, then s_tready drops until the receiver drains.
module broadcast_index_walker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [biw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [biw_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // Request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [biw_pkg::S_TDATA_BITS-1:0]      s_tdata,   // [0] restart, [7:1] zero
    // Result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [biw_pkg::M_TDATA_BITS-1:0]      m_tdata,   // [31:0] out_index,
                                                             // [63:32] lhs_index,
                                                             // [95:64] rhs_index
    output logic                                  m_tlast,   // last
    output logic                                  m_tuser    // [0] size_error
);

    localparam int MD = biw_pkg::MAX_DIMS;
    localparam int DB = biw_pkg::DIM_BITS;
    localparam int IB = biw_pkg::INDEX_BITS;
    localparam int XB = biw_pkg::DIM_IDX_BITS;

    // Configuration registers
    logic [biw_pkg::RANK_BITS-1:0] rank_reg, rank_next;
    logic [DB-1:0]                 dim_size_reg [MD];
    logic [DB-1:0]                 dim_size_next [MD];
    logic [MD-1:0]                 lhs_mask_reg, lhs_mask_next;
    logic [MD-1:0]                 rhs_mask_reg, rhs_mask_next;

    // Strides and running accumulators
    logic [IB-1:0] ostride_reg [MD];
    logic [IB-1:0] ostride_next [MD];
    logic [IB-1:0] lstride_reg [MD];
    logic [IB-1:0] lstride_next [MD];
    logic [IB-1:0] rstride_reg [MD];
    logic [IB-1:0] rstride_next [MD];
    logic [IB-1:0] oacc_reg, oacc_next;
    logic [IB-1:0] lacc_reg, lacc_next;
    logic [IB-1:0] racc_reg, racc_next;
    logic [biw_pkg::TOT_BITS-1:0] tot_reg, tot_next;
    logic          err_reg, err_next;

    // Walk state: coordinates and per-dimension partial offsets
    logic [DB-1:0] coords_reg [MD];
    logic [DB-1:0] coords_next [MD];
    logic [IB-1:0] po_reg [MD];
    logic [IB-1:0] po_next [MD];
    logic [IB-1:0] pl_reg [MD];
    logic [IB-1:0] pl_next [MD];
    logic [IB-1:0] pr_reg [MD];
    logic [IB-1:0] pr_next [MD];

    // Recompute sequencer
    biw_pkg::settle_state_t settle_reg, settle_next;
    logic [XB-1:0] step_reg, step_next;
    logic          step_last;
    logic          busy;
    logic          do_stride;
    logic          do_product;
    logic [XB-1:0] set_dim;

    // Output register and skid
    biw_pkg::result_t out_reg, out_next;
    biw_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    // Derived per-dimension view of the configuration
    logic [biw_pkg::RANK_BITS:0] used_rank;
    logic [MD-1:0]               dim_used;
    logic [DB-1:0]               eff_size [MD];

    logic             cfg_write;
    logic             accept;
    logic             restart;
    biw_pkg::result_t step_res;
    logic [DB-1:0]    coords_step [MD];
    logic [IB-1:0]    po_step [MD];
    logic [IB-1:0]    pl_step [MD];
    logic [IB-1:0]    pr_step [MD];

    logic [IB+DB-1:0]               omul, lmul, rmul;
    logic [biw_pkg::PROD_BITS-1:0]  tmul;
    logic [IB+DB-1:0]               opmul, lpmul, rpmul;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = !busy && !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign restart   = s_tdata[0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.rhs_index, out_reg.lhs_index, out_reg.out_index};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.size_error;

    // Clamp rank to 1..MAX_DIMS and mark the used (innermost) dimensions
    always_comb begin
        if (rank_reg == '0) begin
            used_rank = (biw_pkg::RANK_BITS+1)'(1);
        end else if (int'(rank_reg) > MD) begin
            used_rank = (biw_pkg::RANK_BITS+1)'(MD);
        end else begin
            used_rank = {1'b0, rank_reg};
        end
        for (int d = 0; d < MD; d++) begin
            dim_used[d] = (d + int'(used_rank)) >= MD;
            eff_size[d] = (!dim_used[d] || dim_size_reg[d] == '0)
                          ? DB'(1) : dim_size_reg[d];
        end
    end

    // Recompute sequencer: next state
    assign step_last = (step_reg == XB'(MD - 1));
    always_comb begin
        settle_next = settle_reg;
        step_next   = step_reg;
        if (cfg_write) begin
            settle_next = biw_pkg::SETTLE_STRIDE;
            step_next   = '0;
        end else begin
            case (settle_reg)
                biw_pkg::SETTLE_STRIDE: begin
                    step_next = step_last ? '0 : step_reg + XB'(1);
                    if (step_last) settle_next = biw_pkg::SETTLE_PRODUCT;
                end
                biw_pkg::SETTLE_PRODUCT: begin
                    step_next = step_last ? '0 : step_reg + XB'(1);
                    if (step_last) settle_next = biw_pkg::SETTLE_IDLE;
                end
                default: begin
                    settle_next = biw_pkg::SETTLE_IDLE;
                    step_next   = '0;
                end
            endcase
        end
    end

    // Recompute sequencer: outputs (innermost dimension first)
    always_comb begin
        busy       = (settle_reg != biw_pkg::SETTLE_IDLE);
        do_stride  = (settle_reg == biw_pkg::SETTLE_STRIDE) && !cfg_write;
        do_product = (settle_reg == biw_pkg::SETTLE_PRODUCT) && !cfg_write;
        set_dim    = XB'(MD - 1) - step_reg;
    end

    // Shared multipliers: stride accumulation, element count, partial offsets
    assign omul  = oacc_reg * eff_size[set_dim];
    assign lmul  = lacc_reg * eff_size[set_dim];
    assign rmul  = racc_reg * eff_size[set_dim];
    assign tmul  = tot_reg * eff_size[set_dim];
    assign opmul = ostride_reg[set_dim] * coords_reg[set_dim];
    assign lpmul = lstride_reg[set_dim] * coords_reg[set_dim];
    assign rpmul = rstride_reg[set_dim] * coords_reg[set_dim];

    // Emit the current element and advance the odometer
    always_comb begin
        logic          carry;
        logic [DB-1:0] cc;
        logic [IB-1:0] po, pl, pr;
        logic [IB-1:0] so, sl, sr;
        carry = 1'b1;
        so = '0;
        sl = '0;
        sr = '0;
        for (int d = MD - 1; d >= 0; d--) begin
            cc = restart ? '0 : coords_reg[d];
            po = restart ? '0 : po_reg[d];
            pl = restart ? '0 : pl_reg[d];
            pr = restart ? '0 : pr_reg[d];
            so = so + po;
            sl = sl + pl;
            sr = sr + pr;
            coords_step[d] = cc;
            po_step[d] = po;
            pl_step[d] = pl;
            pr_step[d] = pr;
            if (carry) begin
                if (!dim_used[d] || ({1'b0, cc} + (DB+1)'(1)) >= {1'b0, eff_size[d]}) begin
                    coords_step[d] = '0;
                    po_step[d] = '0;
                    pl_step[d] = '0;
                    pr_step[d] = '0;
                end else begin
                    coords_step[d] = cc + DB'(1);
                    po_step[d] = po + ostride_reg[d];
                    pl_step[d] = pl + lstride_reg[d];
                    pr_step[d] = pr + rstride_reg[d];
                    carry = 1'b0;
                end
            end
        end
        step_res.out_index  = so;
        step_res.lhs_index  = sl;
        step_res.rhs_index  = sr;
        step_res.last       = carry;
        step_res.size_error = err_reg;
    end

    // Next values of configuration, strides and walk state
    always_comb begin
        rank_next     = rank_reg;
        dim_size_next = dim_size_reg;
        lhs_mask_next = lhs_mask_reg;
        rhs_mask_next = rhs_mask_reg;
        ostride_next  = ostride_reg;
        lstride_next  = lstride_reg;
        rstride_next  = rstride_reg;
        oacc_next     = oacc_reg;
        lacc_next     = lacc_reg;
        racc_next     = racc_reg;
        tot_next      = tot_reg;
        err_next      = err_reg;
        coords_next   = coords_reg;
        po_next       = po_reg;
        pl_next       = pl_reg;
        pr_next       = pr_reg;

        // Register writes; unknown indexes drop
        if (cfg_write) begin
            case (biw_pkg::cfg_reg_t'(cfg_index))
                biw_pkg::CFG_RANK:       rank_next = cfg_data[biw_pkg::RANK_BITS-1:0];
                biw_pkg::CFG_DIM_SIZE_0: dim_size_next[0] = cfg_data[DB-1:0];
                biw_pkg::CFG_DIM_SIZE_1: dim_size_next[1] = cfg_data[DB-1:0];
                biw_pkg::CFG_DIM_SIZE_2: dim_size_next[2] = cfg_data[DB-1:0];
                biw_pkg::CFG_DIM_SIZE_3: dim_size_next[3] = cfg_data[DB-1:0];
                biw_pkg::CFG_LHS_MASK:   lhs_mask_next = cfg_data[MD-1:0];
                biw_pkg::CFG_RHS_MASK:   rhs_mask_next = cfg_data[MD-1:0];
                default: ;
            endcase
            oacc_next = IB'(1);
            lacc_next = IB'(1);
            racc_next = IB'(1);
            tot_next  = biw_pkg::TOT_BITS'(1);
            err_next  = 1'b0;
        end

        // Stride pass: broadcast dimensions get stride zero and keep the accumulator
        if (do_stride) begin
            ostride_next[set_dim] = oacc_reg;
            lstride_next[set_dim] = lhs_mask_reg[set_dim] ? '0 : lacc_reg;
            rstride_next[set_dim] = rhs_mask_reg[set_dim] ? '0 : racc_reg;
            oacc_next = omul[IB-1:0];
            if (!lhs_mask_reg[set_dim]) lacc_next = lmul[IB-1:0];
            if (!rhs_mask_reg[set_dim]) racc_next = rmul[IB-1:0];
            if (!err_reg) begin
                if (tmul > (biw_pkg::PROD_BITS'(1) << IB)) begin
                    err_next = 1'b1;
                end else begin
                    tot_next = tmul[biw_pkg::TOT_BITS-1:0];
                end
            end
        end

        // Offset pass: rebuild partial offsets from held coordinates
        if (do_product) begin
            po_next[set_dim] = dim_used[set_dim] ? opmul[IB-1:0] : '0;
            pl_next[set_dim] = dim_used[set_dim] ? lpmul[IB-1:0] : '0;
            pr_next[set_dim] = dim_used[set_dim] ? rpmul[IB-1:0] : '0;
        end

        // Advance on an accepted request
        if (accept) begin
            coords_next = coords_step;
            po_next     = po_step;
            pl_next     = pl_step;
            pr_next     = pr_step;
        end
    end

    // Output register with one skid stage
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_next       = step_res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            skid_next       = step_res;
            skid_valid_next = 1'b1;
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg     <= biw_pkg::SETTLE_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            rank_reg       <= biw_pkg::RANK_BITS'(1);
            lhs_mask_reg   <= '0;
            rhs_mask_reg   <= '0;
            oacc_reg       <= IB'(1);
            lacc_reg       <= IB'(1);
            racc_reg       <= IB'(1);
            tot_reg        <= biw_pkg::TOT_BITS'(1);
            err_reg        <= 1'b0;
            for (int d = 0; d < MD; d++) begin
                dim_size_reg[d] <= DB'(1);
                ostride_reg[d]  <= IB'(1);
                lstride_reg[d]  <= IB'(1);
                rstride_reg[d]  <= IB'(1);
                coords_reg[d]   <= '0;
                po_reg[d]       <= '0;
                pl_reg[d]       <= '0;
                pr_reg[d]       <= '0;
            end
        end else begin
            settle_reg     <= settle_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            rank_reg       <= rank_next;
            lhs_mask_reg   <= lhs_mask_next;
            rhs_mask_reg   <= rhs_mask_next;
            oacc_reg       <= oacc_next;
            lacc_reg       <= lacc_next;
            racc_reg       <= racc_next;
            tot_reg        <= tot_next;
            err_reg        <= err_next;
            dim_size_reg   <= dim_size_next;
            ostride_reg    <= ostride_next;
            lstride_reg    <= lstride_next;
            rstride_reg    <= rstride_next;
            coords_reg     <= coords_next;
            po_reg         <= po_next;
            pl_reg         <= pl_next;
            pr_reg         <= pr_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

>>> sim/index_triple_checker.sv
`timescale 1ns / 1ps
// Result checker for the broadcast index walker: follows configuration writes and
// requests, predicts each index triple and compares it with the result channel.
// Depends on biw_pkg for geometry, register codes and the result type.
module index_triple_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [biw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [biw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [biw_pkg::S_TDATA_BITS-1:0]   s_tdata,   // [0] restart, [7:1] zero
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [biw_pkg::M_TDATA_BITS-1:0]   m_tdata,   // [31:0] out_index,
                                                          // [63:32] lhs_index,
                                                          // [95:64] rhs_index
    input  logic                               m_tlast,   // last
    input  logic                               m_tuser,   // [0] size_error
    output int                                 mismatches,
    output int                                 results_pending
);

    // Own copy of the register file and the odometer
    logic [biw_pkg::RANK_BITS-1:0] rank_q;
    logic [biw_pkg::DIM_BITS-1:0]  size_q [biw_pkg::MAX_DIMS];
    logic [biw_pkg::MAX_DIMS-1:0]  lhs_mask_q;
    logic [biw_pkg::MAX_DIMS-1:0]  rhs_mask_q;
    logic [biw_pkg::DIM_BITS-1:0]  coord_q [biw_pkg::MAX_DIMS];

    biw_pkg::result_t expected_triples [$];
    int               fail_total = 0;

    // Emit the triple for the current coordinates, then advance the odometer
    function automatic biw_pkg::result_t predict_triple(logic restart);
        int               live;
        int               first;
        logic [63:0]      eff [biw_pkg::MAX_DIMS];
        logic [63:0]      o_stride, l_stride, r_stride;
        logic [63:0]      o_sum, l_sum, r_sum;
        logic [63:0]      c, next_c;
        logic             carry;
        biw_pkg::result_t res;
        live = (rank_q == '0) ? 1 :
               (int'(rank_q) > biw_pkg::MAX_DIMS) ? biw_pkg::MAX_DIMS : int'(rank_q);
        first = biw_pkg::MAX_DIMS - live;
        if (restart) begin
            for (int d = 0; d < biw_pkg::MAX_DIMS; d++) coord_q[d] = '0;
        end
        o_stride = 64'd1;
        l_stride = 64'd1;
        r_stride = 64'd1;
        o_sum = '0;
        l_sum = '0;
        r_sum = '0;
        // Accumulate offsets innermost first; broadcast dimensions add nothing
        for (int d = biw_pkg::MAX_DIMS - 1; d >= 0; d--) begin
            eff[d] = (d < first || size_q[d] == '0) ? 64'd1 : 64'(size_q[d]);
            c = (d < first) ? 64'd0 : 64'(coord_q[d]);
            o_sum += c * o_stride;
            o_stride *= eff[d];
            if (!lhs_mask_q[d]) begin
                l_sum += c * l_stride;
                l_stride *= eff[d];
            end
            if (!rhs_mask_q[d]) begin
                r_sum += c * r_stride;
                r_stride *= eff[d];
            end
        end
        // Advance; a held coordinate at or past its size wraps to zero
        carry = 1'b1;
        for (int d = biw_pkg::MAX_DIMS - 1; d >= 0; d--) begin
            if (carry) begin
                if (d < first) begin
                    coord_q[d] = '0;
                end else begin
                    next_c = 64'(coord_q[d]) + 64'd1;
                    if (next_c >= eff[d]) begin
                        coord_q[d] = '0;
                    end else begin
                        coord_q[d] = next_c[biw_pkg::DIM_BITS-1:0];
                        carry = 1'b0;
                    end
                end
            end
        end
        res.out_index  = o_sum[biw_pkg::INDEX_BITS-1:0];
        res.lhs_index  = l_sum[biw_pkg::INDEX_BITS-1:0];
        res.rhs_index  = r_sum[biw_pkg::INDEX_BITS-1:0];
        res.last       = carry;
        res.size_error = (o_stride > (64'd1 << biw_pkg::INDEX_BITS));
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        biw_pkg::result_t seen;
        biw_pkg::result_t want;
        if (!aresetn) begin
            rank_q     = biw_pkg::RANK_BITS'(1);
            lhs_mask_q = '0;
            rhs_mask_q = '0;
            for (int d = 0; d < biw_pkg::MAX_DIMS; d++) begin
                size_q[d]  = biw_pkg::DIM_BITS'(1);
                coord_q[d] = '0;
            end
            expected_triples.delete();
        end else begin
            // Track register writes; drop writes to unknown indexes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    biw_pkg::CFG_RANK:       rank_q     = cfg_data[biw_pkg::RANK_BITS-1:0];
                    biw_pkg::CFG_DIM_SIZE_0: size_q[0]  = cfg_data[biw_pkg::DIM_BITS-1:0];
                    biw_pkg::CFG_DIM_SIZE_1: size_q[1]  = cfg_data[biw_pkg::DIM_BITS-1:0];
                    biw_pkg::CFG_DIM_SIZE_2: size_q[2]  = cfg_data[biw_pkg::DIM_BITS-1:0];
                    biw_pkg::CFG_DIM_SIZE_3: size_q[3]  = cfg_data[biw_pkg::DIM_BITS-1:0];
                    biw_pkg::CFG_LHS_MASK:   lhs_mask_q = cfg_data[biw_pkg::MAX_DIMS-1:0];
                    biw_pkg::CFG_RHS_MASK:   rhs_mask_q = cfg_data[biw_pkg::MAX_DIMS-1:0];
                    default: ;
                endcase
            end
            // Compare each result word with the oldest prediction
            if (m_tvalid && m_tready) begin
                seen.out_index  = m_tdata[biw_pkg::INDEX_BITS-1:0];
                seen.lhs_index  = m_tdata[2*biw_pkg::INDEX_BITS-1:biw_pkg::INDEX_BITS];
                seen.rhs_index  = m_tdata[3*biw_pkg::INDEX_BITS-1:2*biw_pkg::INDEX_BITS];
                seen.last       = m_tlast;
                seen.size_error = m_tuser;
                if (expected_triples.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result word with no request outstanding: out=%h",
                                 $time, seen.out_index);
                end else begin
                    want = expected_triples.pop_front();
                    if (seen !== want) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"%0t: triple mismatch: expected out=%h lhs=%h rhs=%h ",
                                      "last=%b size_error=%b, got out=%h lhs=%h rhs=%h ",
                                      "last=%b size_error=%b"},
                                     $time, want.out_index, want.lhs_index, want.rhs_index,
                                     want.last, want.size_error, seen.out_index,
                                     seen.lhs_index, seen.rhs_index, seen.last,
                                     seen.size_error);
                    end
                end
            end
            // Predict the triple for each accepted request word
            if (s_tvalid && s_tready)
                expected_triples.push_back(predict_triple(s_tdata[0]));
        end
        mismatches      <= fail_total;
        results_pending <= expected_triples.size();
    end

endmodule

>>> sim/broadcast_index_walker_test.sv
`timescale 1ns / 1ps
// Testbench top for the broadcast index walker: drives configuration and request
// words with random gaps and stalls, and gives the verdict from index_triple_checker.
// Depends on biw_pkg, broadcast_index_walker and index_triple_checker.
module broadcast_index_walker_test;

    localparam logic [biw_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED =
        biw_pkg::CFG_INDEX_BITS'(7);
    localparam int TOTAL_ITEMS = 1875;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [biw_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [biw_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [biw_pkg::S_TDATA_BITS-1:0]   s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [biw_pkg::M_TDATA_BITS-1:0]   m_tdata;
    logic                               m_tlast;
    logic                               m_tuser;

    int mismatches;
    int results_pending;
    int items_sent = 0;
    bit send_calm  = 1'b0;
    bit sink_calm  = 1'b0;

    broadcast_index_walker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    index_triple_checker triple_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop for a hung handshake
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Wait length for one word; calm stretches switch idling off for a while
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 24) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic logic [biw_pkg::RANK_BITS-1:0] pick_rank();
        if ($urandom_range(0, 99) < 80)
            return biw_pkg::RANK_BITS'($urandom_range(1, biw_pkg::MAX_DIMS));
        return biw_pkg::RANK_BITS'($urandom_range(0, 7));
    endfunction

    // Mostly short dimensions so walks finish; some zero, full and random sizes
    function automatic logic [biw_pkg::CFG_DATA_BITS-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return biw_pkg::CFG_DATA_BITS'($urandom_range(1, 5));
        if (roll < 80) return biw_pkg::CFG_DATA_BITS'($urandom_range(6, 40));
        if (roll < 85) return '0;
        if (roll < 92) return '1;
        return biw_pkg::CFG_DATA_BITS'($urandom());
    endfunction

    // Hold cfg_valid across back-to-back writes; the request run lowers it
    task automatic write_reg(input logic [biw_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [biw_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic send_request(input bit restart);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(biw_pkg::S_TDATA_BITS-1){1'b0}}, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Send a run of request words, then hold until every result word is back
    task automatic request_run(input int count, input bit first_restart,
                               input int restart_odds);
        cfg_valid <= 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i == 0)
                send_request(first_restart);
            else
                send_request(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    task automatic pick_config();
        logic [biw_pkg::CFG_DATA_BITS-1:0] word;
        bit                                wrote;
        wrote = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            word = biw_pkg::CFG_DATA_BITS'($urandom());
            word[biw_pkg::RANK_BITS-1:0] = pick_rank();
            write_reg(biw_pkg::CFG_RANK, word);
            wrote = 1'b1;
        end
        for (int d = 0; d < biw_pkg::MAX_DIMS; d++) begin
            if ($urandom_range(0, 1) == 1) begin
                write_reg(biw_pkg::CFG_INDEX_BITS'(biw_pkg::CFG_DIM_SIZE_0 + d),
                          pick_size());
                wrote = 1'b1;
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            write_reg(biw_pkg::CFG_LHS_MASK, biw_pkg::CFG_DATA_BITS'($urandom()));
            wrote = 1'b1;
        end
        if ($urandom_range(0, 1) == 1 || !wrote)
            write_reg(biw_pkg::CFG_RHS_MASK, biw_pkg::CFG_DATA_BITS'($urandom()));
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED, biw_pkg::CFG_DATA_BITS'($urandom()));
    endtask

    // Result side: random stalls between words
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: every element is the last one
        request_run(2, 1'b0, 1);

        // Rank zero behaves as rank one; walk of three
        write_reg(biw_pkg::CFG_RANK, 16'hFFF8);
        write_reg(biw_pkg::CFG_DIM_SIZE_3, 16'd3);
        request_run(3, 1'b0, 0);

        // Rank above four saturates, zero size acts as one, opposite masks
        write_reg(biw_pkg::CFG_RANK, 16'h0007);
        write_reg(biw_pkg::CFG_DIM_SIZE_0, 16'd2);
        write_reg(biw_pkg::CFG_DIM_SIZE_1, 16'd3);
        write_reg(biw_pkg::CFG_DIM_SIZE_2, 16'd0);
        write_reg(biw_pkg::CFG_DIM_SIZE_3, 16'd2);
        write_reg(biw_pkg::CFG_LHS_MASK, 16'h0005);
        write_reg(biw_pkg::CFG_RHS_MASK, 16'h000A);
        request_run(5, 1'b1, 0);

        // Shrink the inner dimension under a held coordinate
        write_reg(biw_pkg::CFG_DIM_SIZE_3, 16'd1);
        request_run(3, 1'b0, 0);

        // Full sizes: element count overflows, indices wrap
        write_reg(biw_pkg::CFG_DIM_SIZE_0, 16'hFFFF);
        write_reg(biw_pkg::CFG_DIM_SIZE_1, 16'hFFFF);
        write_reg(biw_pkg::CFG_DIM_SIZE_2, 16'hFFFF);
        write_reg(biw_pkg::CFG_DIM_SIZE_3, 16'hFFFF);
        write_reg(biw_pkg::CFG_LHS_MASK, 16'h000F);
        write_reg(biw_pkg::CFG_RHS_MASK, 16'h0000);
        request_run(3, 1'b0, 0);

        // Exactly 2^32 elements, then one inner size past it
        write_reg(biw_pkg::CFG_RANK, 16'd3);
        write_reg(biw_pkg::CFG_DIM_SIZE_1, 16'h8000);
        write_reg(biw_pkg::CFG_DIM_SIZE_2, 16'h8000);
        write_reg(biw_pkg::CFG_DIM_SIZE_3, 16'd4);
        write_reg(biw_pkg::CFG_LHS_MASK, 16'h0000);
        write_reg(biw_pkg::CFG_RHS_MASK, 16'h000F);
        request_run(2, 1'b1, 0);
        write_reg(biw_pkg::CFG_DIM_SIZE_3, 16'd5);
        request_run(2, 1'b0, 0);

        // Write to an unknown index must change nothing
        write_reg(CFG_UNUSED, 16'hFFFF);
        request_run(1, 1'b0, 0);

        // Random settings, walks carried across setting changes
        while (items_sent < TOTAL_ITEMS) begin
            pick_config();
            request_run($urandom_range(4, 60), $urandom_range(0, 5) == 0, 30);
        end

        repeat (16) @(posedge aclk);
        if (mismatches == 0 && results_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> broadcast_index_walker.f
hdl/biw_pkg.sv
hdl/broadcast_index_walker.sv
sim/index_triple_checker.sv
sim/broadcast_index_walker_test.sv
